@@ design/tnpd_pkg.sv @@
package tnpd_pkg;

  // table depth and derived widths
  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned PTR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);

  // fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned HALF_W     = SIZE_W - 1;
  localparam int unsigned SQ_W       = 2 * COORD_W;
  localparam int unsigned DIST_W     = 23;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // grid size limits
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 12'd1;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = 12'd2048;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd512;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SELECT = 2'd2
  } cfg_idx_e;

  // query moving down the cell row with its running minima
  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [DIST_W-1:0]  best;
    logic [DIST_W-1:0]  second;
  } query_t;

  // grid geometry and fill level shared by every cell
  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [HALF_W-1:0] half_x;
    logic [HALF_W-1:0] half_y;
    logic [CNT_W-1:0]  count;
  } cell_ctl_t;

  // magnitude of the wrapped per-axis gap
  function automatic logic [COORD_W-1:0] axis_mag(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b,
                                                  input logic [SIZE_W-1:0]  size,
                                                  input logic [HALF_W-1:0]  half);
    logic [COORD_W-1:0] d;
    logic [SIZE_W:0]    g;
    logic [SIZE_W:0]    m;
    d = (a >= b) ? (a - b) : (b - a);
    g = {1'b0, size} - {2'b0, d};
    m = g[SIZE_W] ? (~g + 1'b1) : g;
    if (d > half) begin
      return m[COORD_W-1:0];
    end
    return d;
  endfunction

endpackage

@@ design/tnpd_if.sv @@
interface tnpd_in_if;
  import tnpd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  modport source (output valid, output command, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input command, input coord_x, input coord_y, output ready);
endinterface

interface tnpd_out_if;
  import tnpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_sq;
  modport source (output valid, output distance_sq, input ready);
  modport sink   (input valid, input distance_sq, output ready);
endinterface

interface tnpd_cfg_if;
  import tnpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/tnpd_cell.sv @@
module tnpd_cell import tnpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [PTR_W-1:0]   idx_i,
  input  cell_ctl_t          ctl_i,
  input  logic               wr_en_i,
  input  logic [COORD_W-1:0] wr_x_i,
  input  logic [COORD_W-1:0] wr_y_i,
  input  logic               valid_i,
  input  query_t             query_i,
  output logic               valid_o,
  output query_t             query_o
);

  logic [COORD_W-1:0] pt_x_q, pt_y_q;

  logic               v1_q, v2_q, v3_q;
  query_t             q1_q, q2_q, q3_q;
  logic               use1_q, use2_q;
  logic [COORD_W-1:0] mx_d, my_d, mx_q, my_q;
  logic [SQ_W-1:0]    sx_d, sy_d, sx_q, sy_q;
  logic               use1_d;
  logic [DIST_W-1:0]  sum_sq;
  query_t             q3_d;

  // stored feature point
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pt_x_q <= wr_x_i;
      pt_y_q <= wr_y_i;
    end
  end

  // stage 1: wrapped gaps, entry live only below the fill level
  always_comb begin
    use1_d = CNT_W'(idx_i) < ctl_i.count;
    mx_d   = axis_mag(pt_x_q, query_i.px, ctl_i.size_x, ctl_i.half_x);
    my_d   = axis_mag(pt_y_q, query_i.py, ctl_i.size_y, ctl_i.half_y);
  end

  // stage 2: squares
  always_comb begin
    sx_d = SQ_W'(mx_q) * SQ_W'(mx_q);
    sy_d = SQ_W'(my_q) * SQ_W'(my_q);
  end

  // stage 3: sum and minima update, ties go to the second slot
  always_comb begin
    sum_sq = DIST_W'(sx_q) + DIST_W'(sy_q);
    q3_d   = q2_q;
    if (use2_q && (sum_sq < q2_q.best)) begin
      q3_d.second = q2_q.best;
      q3_d.best   = sum_sq;
    end else if (use2_q && (sum_sq < q2_q.second)) begin
      q3_d.second = sum_sq;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      q1_q   <= query_i;
      mx_q   <= mx_d;
      my_q   <= my_d;
      use1_q <= use1_d;
      q2_q   <= q1_q;
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      use2_q <= use1_q;
      q3_q   <= q3_d;
    end
  end

  assign valid_o = v3_q;
  assign query_o = q3_q;

endmodule

@@ design/toroidal_nearest_point_distance_unit.sv @@
// channel  | dir | beat                            | notes
// in_i     | in  | command, coord_x, coord_y       | clear, add point, query pixel
// out_o    | out | distance_sq                     | one beat per query, in order
// cfg_i    | in  | index, data                     | grid_width, grid_height, select_second
//
// queries stream one per cycle, unless out_o stalls, through a row of MAX_POINTS cells, three stages each
// a query beat passes the entry stage, every cell and the output register on its way to out_o
// clear and add are held off until no query is left in the row
// a stalled out_o freezes the whole row; reset empties the table and the row at once
// cfg_i is always ready; registers reset to 512, 512, 0
module toroidal_nearest_point_distance_unit import tnpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tnpd_in_if.sink   in_i,
  tnpd_out_if.source out_o,
  tnpd_cfg_if.sink  cfg_i
);

  localparam int unsigned INF_W = $clog2(3 * MAX_POINTS + 2);

  logic [SIZE_W-1:0]   width_q, height_q;
  logic                sel_q;
  logic [CNT_W-1:0]    count_q;
  logic [INF_W-1:0]    inflight_q;
  logic                v0_q;
  query_t              q0_q;
  logic                out_v_q;
  logic [DIST_W-1:0]   out_d_q;

  cell_ctl_t           ctl;
  logic [2*SIZE_W-1:0] area;
  logic                adv, is_query, in_acc, cfg_acc, add_we, full;
  logic                inf_inc, inf_dec;
  logic [MAX_POINTS-1:0] cell_we;
  logic                valid_c [0:MAX_POINTS];
  query_t              query_c [0:MAX_POINTS];

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return SIZE_MIN;
    end
    if (v > SIZE_MAX) begin
      return SIZE_MAX;
    end
    return v;
  endfunction

  // configuration registers
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
      sel_q    <= 1'b0;
    end else if (cfg_acc) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_WIDTH:  width_q  <= cfg_i.data;
        CFG_HEIGHT: height_q <= cfg_i.data;
        CFG_SELECT: sel_q    <= cfg_i.data[0];
        default:    ;
      endcase
    end
  end

  // geometry shared by the row
  always_comb begin
    ctl.size_x = clamp_size(width_q);
    ctl.size_y = clamp_size(height_q);
    ctl.half_x = ctl.size_x[SIZE_W-1:1];
    ctl.half_y = ctl.size_y[SIZE_W-1:1];
    ctl.count  = count_q;
    area       = ctl.size_x * ctl.size_y;
  end

  // input handshake: table changes wait for an empty row
  assign adv      = !out_v_q || out_o.ready;
  assign is_query = (in_i.command == CMD_QUERY);
  assign in_i.ready = is_query ? adv : (inflight_q == '0);
  assign in_acc   = in_i.valid && in_i.ready;
  assign full     = (count_q >= CNT_W'(MAX_POINTS));
  assign add_we   = in_acc && (in_i.command == CMD_ADD) && !full;

  // fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_acc && (in_i.command == CMD_CLEAR)) begin
      count_q <= '0;
    end else if (add_we) begin
      count_q <= count_q + 1'b1;
    end
  end

  // queries in the row or entry stage
  assign inf_inc = in_acc && is_query;
  assign inf_dec = adv && valid_c[MAX_POINTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (inf_inc && !inf_dec) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (inf_dec && !inf_inc) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  // entry stage seeds both minima with the grid area
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= inf_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q0_q.px     <= in_i.coord_x;
      q0_q.py     <= in_i.coord_y;
      q0_q.best   <= area[DIST_W-1:0];
      q0_q.second <= area[DIST_W-1:0];
    end
  end

  assign valid_c[0] = v0_q;
  assign query_c[0] = q0_q;

  // row of point cells
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    assign cell_we[k] = add_we && (count_q[PTR_W-1:0] == PTR_W'(k));

    tnpd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .idx_i   (PTR_W'(k)),
      .ctl_i   (ctl),
      .wr_en_i (cell_we[k]),
      .wr_x_i  (in_i.coord_x),
      .wr_y_i  (in_i.coord_y),
      .valid_i (valid_c[k]),
      .query_i (query_c[k]),
      .valid_o (valid_c[k+1]),
      .query_o (query_c[k+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= valid_c[MAX_POINTS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_d_q <= sel_q ? query_c[MAX_POINTS].second : query_c[MAX_POINTS].best;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.distance_sq = out_d_q;

  // checks
  a_count_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q != '0) |=> $stable(count_q))
    else $error("table changed under an in-flight query");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("fill level beyond table depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inf_dec |-> (inflight_q != '0))
    else $error("query left the row without being counted");

  a_empty_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == '0) |-> (!v0_q && !valid_c[MAX_POINTS]))
    else $error("row holds a query while counted empty");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(valid_c[MAX_POINTS]))
    else $error("output beat without a query from the row");

endmodule
